/* rtl/cascaded_biquad_iir_filter_assert.svh */
`ifndef CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cascaded_biquad_iir_filter: assertion failed");

// Next-cycle implication, disabled during reset.
`define CBQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cascaded_biquad_iir_filter: assertion failed");

`endif

/* rtl/cbq_pkg.sv */
package cbq_pkg;

   localparam int MAX_SECTIONS_DEF = 8;
   localparam int DATA_WIDTH_DEF   = 24;
   localparam int COEF_WIDTH_DEF   = 24;

   localparam int NCOEF       = 5;
   localparam int COEF_FRAC   = 20;
   localparam int SAMPLE_FRAC = 8;
   localparam int SAMPLE_W    = 16;
   localparam int COEF_FIELD_W = 24;
   localparam int SECT_FIELD_W = 3;
   localparam int CFG_W       = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [0:0] REG_SECTIONS = 1'b0;

   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_LOAD   = 1'b1
   } cbq_op_type;

   typedef enum logic [2:0] {
      C_B0 = 3'd0,
      C_B1 = 3'd1,
      C_B2 = 3'd2,
      C_A1 = 3'd3,
      C_A2 = 3'd4
   } cbq_coef_type;

   typedef struct packed {
      logic         we;
      cbq_coef_type idx;
   } cbq_coef_wr_type;

   typedef struct packed {
      logic valid;
      logic sat;
   } cbq_tok_type;

endpackage

/* rtl/cbq_if.sv */
interface cbq_req_if import cbq_pkg::*; ();
   logic                           valid;
   logic                           ready;
   cbq_op_type                     opcode;
   logic signed [SAMPLE_W-1:0]     sample;
   logic                           last_of_run;
   logic [SECT_FIELD_W-1:0]        section_index;
   logic [2:0]                     coef_index;
   logic signed [COEF_FIELD_W-1:0] coef_value;

   modport source (output valid, opcode, sample, last_of_run, section_index, coef_index,
                   coef_value, input ready);
   modport sink (input valid, opcode, sample, last_of_run, section_index, coef_index,
                 coef_value, output ready);
endinterface

interface cbq_rsp_if import cbq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered;
   logic                       last_out;
   logic                       saturated;

   modport source (output valid, filtered, last_out, saturated, input ready);
   modport sink (input valid, filtered, last_out, saturated, output ready);
endinterface

/* rtl/cbq_cell.sv */
module cbq_cell import cbq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cbq_coef_wr_type              coef_wr,
   input  logic signed [COEF_WIDTH-1:0] coef_val,
   input  logic                         clear,
   input  cbq_tok_type                  tok_up,
   input  logic signed [DATA_WIDTH-1:0] x_up,
   output cbq_tok_type                  tok_dn,
   output logic signed [DATA_WIDTH-1:0] y_dn
);

   localparam int PW = COEF_WIDTH + DATA_WIDTH;
   localparam int AW = PW + 3;
   localparam int RW = AW - COEF_FRAC;
   localparam int SW = ((RW > DATA_WIDTH) ? RW : DATA_WIDTH) + 1;
   localparam logic signed [AW-1:0] RND = AW'(1) << (COEF_FRAC - 1);
   localparam logic signed [SW-1:0] Y_MAX = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] Y_MIN = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   logic signed [COEF_WIDTH-1:0] coef_ff [NCOEF];
   logic signed [DATA_WIDTH-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [DATA_WIDTH-1:0] xa_ff;
   logic signed [PW-1:0]         prod_ff [NCOEF];
   logic signed [PW-1:0]         prod_in [NCOEF];
   logic                         va_ff;
   logic                         sa_ff;
   cbq_tok_type                  tok_ff;
   logic signed [DATA_WIDTH-1:0] y_ff, y_in;
   logic                         sat_in;
   logic signed [AW-1:0]         acc;
   logic signed [RW-1:0]         acc_sh;
   logic signed [SW-1:0]         acc_ext;

   always_comb begin
      prod_in[0] = PW'(coef_ff[0]) * PW'(x_up);
      prod_in[1] = PW'(coef_ff[1]) * PW'(x1_ff);
      prod_in[2] = PW'(coef_ff[2]) * PW'(x2_ff);
      prod_in[3] = PW'(coef_ff[3]) * PW'(y1_ff);
      prod_in[4] = PW'(coef_ff[4]) * PW'(y2_ff);
   end

   always_comb begin
      acc = AW'(prod_ff[0]) + AW'(prod_ff[1]) + AW'(prod_ff[2])
          - AW'(prod_ff[3]) - AW'(prod_ff[4]) + RND;
      acc_sh  = signed'(acc[AW-1:COEF_FRAC]);
      acc_ext = SW'(acc_sh);
      sat_in  = sa_ff;
      if (acc_ext > Y_MAX) begin
         y_in   = Y_MAX[DATA_WIDTH-1:0];
         sat_in = 1'b1;
      end else if (acc_ext < Y_MIN) begin
         y_in   = Y_MIN[DATA_WIDTH-1:0];
         sat_in = 1'b1;
      end else begin
         y_in = acc_ext[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCOEF; i++) begin
            coef_ff[i] <= '0;
         end
         x1_ff  <= '0;
         x2_ff  <= '0;
         y1_ff  <= '0;
         y2_ff  <= '0;
         va_ff  <= 1'b0;
         tok_ff <= '0;
      end else begin
         va_ff        <= tok_up.valid;
         tok_ff.valid <= va_ff;
         if (va_ff) begin
            tok_ff.sat <= sat_in;
         end
         if (coef_wr.we) begin
            unique case (coef_wr.idx)
               C_B0: coef_ff[0] <= coef_val;
               C_B1: coef_ff[1] <= coef_val;
               C_B2: coef_ff[2] <= coef_val;
               C_A1: coef_ff[3] <= coef_val;
               C_A2: coef_ff[4] <= coef_val;
               default: ;
            endcase
         end
         if (clear) begin
            x1_ff <= '0;
            x2_ff <= '0;
            y1_ff <= '0;
            y2_ff <= '0;
         end else if (va_ff) begin
            x2_ff <= x1_ff;
            x1_ff <= xa_ff;
            y2_ff <= y1_ff;
            y1_ff <= y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok_up.valid) begin
         for (int i = 0; i < NCOEF; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         xa_ff <= x_up;
         sa_ff <= tok_up.sat;
      end
      if (va_ff) begin
         y_ff <= y_in;
      end
   end

   assign tok_dn = tok_ff;
   assign y_dn   = y_ff;

endmodule

/* rtl/cascaded_biquad_iir_filter.sv */
// Cascade of up to MAX_SECTIONS second-order IIR sections in direct form I, one cell per
// section, each cell with five Q3.20 coefficient multipliers. A sample enters the first
// cell and moves down the row through a multiply stage and a sum, round and saturate stage
// in each section, and no new item is accepted while a sample is in the row or its result
// waits to enter the output register; a coefficient load gives no result. The finished
// result sits in an output register, so a new item is accepted while it waits for its
// transfer. The section count register (address 0) is treated as 1 when zero and limited
// to MAX_SECTIONS; a sample with last_of_run set clears all section history once its
// result is formed.
`include "cascaded_biquad_iir_filter_assert.svh"

module cascaded_biquad_iir_filter import cbq_pkg::*; #(
   parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cbq_req_if.sink               req_bus,
   cbq_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNTW = $clog2(MAX_SECTIONS + 1);
   localparam int SIW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int XW   = ((DATA_WIDTH > SAMPLE_W + SAMPLE_FRAC) ?
                          DATA_WIDTH : SAMPLE_W + SAMPLE_FRAC) + 1;
   localparam logic signed [XW-1:0] X_MAX =
      {{(XW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [XW-1:0] X_MIN =
      {{(XW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
   localparam int OSW = DATA_WIDTH + 1 - SAMPLE_FRAC;
   localparam int OW  = ((OSW > SAMPLE_W) ? OSW : SAMPLE_W) + 1;
   localparam logic signed [DATA_WIDTH:0] O_RND = (DATA_WIDTH+1)'(1) << (SAMPLE_FRAC - 1);
   localparam logic signed [OW-1:0] O_MAX = {{(OW-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [OW-1:0] O_MIN = {{(OW-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [CFG_W-1:0]             sections_ff;
   logic [CNTW-1:0]              count;
   logic [SIW-1:0]               last_idx;
   logic [SIW-1:0]               last_idx_ff;
   logic [MAX_SECTIONS-1:0]      sect_en;
   logic [MAX_SECTIONS-1:0]      cell_valid;
   logic                         req_fire;
   logic                         csr_write;
   logic                         load_ok;
   logic                         slot_free;
   logic                         clear;
   logic                         last_ff;

   logic signed [XW-1:0]         x_wide;
   logic signed [DATA_WIDTH-1:0] x0_in, x0_ff;
   logic                         sat0_in;
   cbq_tok_type                  tok0_ff;
   logic signed [31:0]           coef_wide;
   logic signed [COEF_WIDTH-1:0] coef_val;
   cbq_coef_wr_type              coef_wr [MAX_SECTIONS];

   cbq_tok_type                  tok_up [MAX_SECTIONS];
   cbq_tok_type                  tok_dn [MAX_SECTIONS];
   logic signed [DATA_WIDTH-1:0] x_up [MAX_SECTIONS];
   logic signed [DATA_WIDTH-1:0] y_dn [MAX_SECTIONS];

   logic signed [DATA_WIDTH-1:0] y_sel;
   logic signed [DATA_WIDTH:0]   y_sum;
   logic signed [OSW-1:0]        y_sh;
   logic signed [OW-1:0]         y_ext;
   logic signed [SAMPLE_W-1:0]   out_in;
   logic                         out_sat_in;

   logic                         rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]   rsp_filtered_ff;
   logic                         rsp_last_ff;
   logic                         rsp_sat_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_SECTIONS) begin
         csr_prdata = CSR_DATA_W'(sections_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sections_ff <= CFG_W'(1);
      end else if (csr_write && csr_paddr[CSR_ADDR_W-1:2] == REG_SECTIONS) begin
         sections_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      if (sections_ff == '0) begin
         count = CNTW'(1);
      end else if (32'(sections_ff) > MAX_SECTIONS) begin
         count = CNTW'(MAX_SECTIONS);
      end else begin
         count = CNTW'(sections_ff);
      end
      last_idx = SIW'(count - CNTW'(1));
      for (int k = 0; k < MAX_SECTIONS; k++) begin
         sect_en[k] = (k < 32'(count));
      end
   end

   // Sample widening and coefficient load decode
   always_comb begin
      x_wide  = XW'(signed'({req_bus.sample, {SAMPLE_FRAC{1'b0}}}));
      sat0_in = 1'b0;
      if (x_wide > X_MAX) begin
         x0_in   = X_MAX[DATA_WIDTH-1:0];
         sat0_in = 1'b1;
      end else if (x_wide < X_MIN) begin
         x0_in   = X_MIN[DATA_WIDTH-1:0];
         sat0_in = 1'b1;
      end else begin
         x0_in = x_wide[DATA_WIDTH-1:0];
      end
      coef_wide = 32'(req_bus.coef_value);
      coef_val  = coef_wide[COEF_WIDTH-1:0];
      load_ok   = req_fire && (req_bus.opcode == OP_LOAD)
                  && (req_bus.coef_index <= C_A2)
                  && (32'(req_bus.section_index) < MAX_SECTIONS);
   end

   // Result rounding from the last active section
   always_comb begin
      y_sel      = y_dn[last_idx_ff];
      y_sum      = (DATA_WIDTH+1)'(y_sel) + O_RND;
      y_sh       = signed'(y_sum[DATA_WIDTH:SAMPLE_FRAC]);
      y_ext      = OW'(y_sh);
      out_sat_in = tok_dn[last_idx_ff].sat;
      if (y_ext > O_MAX) begin
         out_in     = O_MAX[SAMPLE_W-1:0];
         out_sat_in = 1'b1;
      end else if (y_ext < O_MIN) begin
         out_in     = O_MIN[SAMPLE_W-1:0];
         out_sat_in = 1'b1;
      end else begin
         out_in = y_ext[SAMPLE_W-1:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign clear     = (state_ff == S_FINISH) && slot_free && last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_bus.opcode == OP_FILTER) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (cell_valid[last_idx_ff]) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tok0_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tok0_ff.valid <= req_fire && (req_bus.opcode == OP_FILTER);
         if (state_ff == S_FINISH && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         x0_ff       <= x0_in;
         tok0_ff.sat <= sat0_in;
         last_ff     <= req_bus.last_of_run;
         last_idx_ff <= last_idx;
      end
      if (state_ff == S_FINISH && slot_free) begin
         rsp_filtered_ff <= out_in;
         rsp_last_ff     <= last_ff;
         rsp_sat_ff      <= out_sat_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.filtered  = rsp_filtered_ff;
   assign rsp_bus.last_out  = rsp_last_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

   // Row of section cells
   for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign tok_up[k] = tok0_ff;
         assign x_up[k]   = x0_ff;
      end else begin : g_link
         assign tok_up[k].valid = tok_dn[k-1].valid && sect_en[k];
         assign tok_up[k].sat   = tok_dn[k-1].sat;
         assign x_up[k]         = y_dn[k-1];
      end

      assign coef_wr[k].we  = load_ok && (32'(req_bus.section_index) == k);
      assign coef_wr[k].idx = cbq_coef_type'(req_bus.coef_index);
      assign cell_valid[k]  = tok_dn[k].valid;

      cbq_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .COEF_WIDTH (COEF_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .coef_wr  (coef_wr[k]),
         .coef_val (coef_val),
         .clear    (clear),
         .tok_up   (tok_up[k]),
         .x_up     (x_up[k]),
         .tok_dn   (tok_dn[k]),
         .y_dn     (y_dn[k])
      );
   end

   `CBQ_ASSERT_IMPL(a_single_token, 1'b1, $onehot0(cell_valid))
   `CBQ_ASSERT_NEXT(a_result_waits, state_ff == S_FINISH && !slot_free, state_ff == S_FINISH)
   `CBQ_ASSERT_NEXT(a_sample_blocks, req_fire && req_bus.opcode == OP_FILTER, !req_bus.ready)

endmodule
